[src/mim_pkg.sv]
// Shared types, constants and arithmetic helpers for the mecanum input matrix block.
// No dependencies; mim_cfg, mim_front, mim_fifo, mim_back and the top level import this package.
package mim_pkg;

    localparam int WHEEL_COUNT = 4;

    // Configuration register indexes.
    localparam logic [7:0] REG_MASS            = 8'd0;
    localparam logic [7:0] REG_INERTIA         = 8'd1;
    localparam logic [7:0] REG_LINEAR_DAMPING  = 8'd2;
    localparam logic [7:0] REG_ANGULAR_DAMPING = 8'd3;
    localparam logic [7:0] REG_MOTOR_GAIN      = 8'd4;
    localparam logic [7:0] REG_WHEEL_RADIUS    = 8'd5;
    localparam logic [7:0] REG_HALF_LENGTH_X   = 8'd6;
    localparam logic [7:0] REG_HALF_LENGTH_Y   = 8'd7;

    // Wheel column codes.
    localparam logic [1:0] WHEEL_FL = 2'd0;
    localparam logic [1:0] WHEEL_FR = 2'd1;
    localparam logic [1:0] WHEEL_RL = 2'd2;
    localparam logic [1:0] WHEEL_RR = 2'd3;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [31:0] MAG_FULL = 32'h8000_0000;

    // One angle as handed from the front to the back: the two heading
    // combinations c+s and c-s in sign and magnitude form.
    typedef struct packed {
        logic        neg_sum;
        logic [17:0] mag_sum;
        logic        neg_dif;
        logic [17:0] mag_dif;
    } t_job;

    // Values that follow from the configuration alone.
    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] scale;
        logic [31:0] turn_mag;
        logic [31:0] lin_term;
        logic [31:0] ang_term;
    } t_derived;

    typedef enum logic [3:0] {
        CF_S_GO, CF_S_WAIT, CF_TAU, CF_T_GO, CF_T_WAIT,
        CF_L_GO, CF_L_WAIT, CF_A_GO, CF_A_WAIT, CF_DONE
    } t_cfg_state;

    typedef enum logic [2:0] {
        BK_IDLE, BK_MUL, BK_GO, BK_WAIT, BK_LOAD
    } t_back_state;

    function automatic logic signed [33:0] cordic_atan(input int idx);
        logic signed [33:0] v;
        case (idx)
            0:       v = 34'sd536870912;
            1:       v = 34'sd316933406;
            2:       v = 34'sd167458907;
            3:       v = 34'sd85004756;
            4:       v = 34'sd42667331;
            5:       v = 34'sd21354465;
            6:       v = 34'sd10679838;
            7:       v = 34'sd5340245;
            8:       v = 34'sd2670163;
            9:       v = 34'sd1335087;
            10:      v = 34'sd667544;
            11:      v = 34'sd333772;
            12:      v = 34'sd166886;
            13:      v = 34'sd83443;
            14:      v = 34'sd41722;
            default: v = 34'sd20861;
        endcase
        return v;
    endfunction

    // Limit a quotient to 2^31, the largest magnitude that still matters
    // for a signed 32-bit result.
    function automatic logic [31:0] cap_mag(input logic sat, input logic [31:0] quo);
        return (sat || quo[31]) ? MAG_FULL : quo;
    endfunction

    // Apply a sign to a capped magnitude with saturation.
    function automatic logic [31:0] sat_signed(input logic neg, input logic [31:0] mag);
        logic [31:0] r;
        if (!neg) begin
            r = (mag == MAG_FULL) ? 32'h7FFF_FFFF : mag;
        end else begin
            r = (mag == MAG_FULL) ? MAG_FULL : (32'd0 - mag);
        end
        return r;
    endfunction

endpackage

[src/mim_if.sv]
// Handshake interfaces of the mecanum input matrix block: heading input,
// column output and configuration write channel. Depends on nothing.
interface mim_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading_angle;
    modport source (output valid, output heading_angle, input ready);
    modport sink   (input valid, input heading_angle, output ready);
endinterface

interface mim_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         wheel_index;
    logic signed [31:0] world_x_gain;
    logic signed [31:0] world_y_gain;
    logic signed [31:0] turn_gain;
    logic signed [31:0] linear_damping_term;
    logic signed [31:0] angular_damping_term;
    logic               last_column;
    modport source (output valid, output wheel_index, output world_x_gain,
                    output world_y_gain, output turn_gain, output linear_damping_term,
                    output angular_damping_term, output last_column, input ready);
    modport sink   (input valid, input wheel_index, input world_x_gain,
                    input world_y_gain, input turn_gain, input linear_damping_term,
                    input angular_damping_term, input last_column, output ready);
endinterface

interface mim_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/mim_div.sv]
// Restoring divider, one quotient bit per cycle, 32-bit quotient with a
// saturation flag. Depends on nothing.
module mim_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic        o_sat
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [62:0] r_dsh;
    logic [31:0] r_quo;
    logic        r_sat;
    logic        w_sat;
    logic        w_quick;
    logic        w_fit;

    // The quotient has at most 32 bits unless the dividend reaches den<<32;
    // a zero dividend always gives zero, even over a zero divisor.
    assign w_sat   = (i_num != 64'd0) && (i_num >= {i_den, 32'd0});
    assign w_quick = (i_num == 64'd0) || w_sat;
    assign w_fit   = r_rem >= {1'b0, r_dsh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= (i_start && !r_busy && w_quick) || (r_busy && r_cnt == 6'd1);
            if (i_start && !r_busy) begin
                if (!w_quick) begin
                    r_busy <= 1'b1;
                    r_cnt  <= 6'd32;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= i_num;
            r_dsh <= {i_den, 31'd0};
            r_quo <= 32'd0;
            r_sat <= w_sat;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - {1'b0, r_dsh};
            end
            r_quo <= {r_quo[30:0], w_fit};
            r_dsh <= {1'b0, r_dsh[62:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_sat  = r_sat;
endmodule

[src/mim_cfg.sv]
// Configuration registers and the sequencer that derives the wheel scale,
// turn magnitude and damping terms from them. Depends on mim_pkg, mim_if, mim_div.
module mim_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mim_cfg_if.sink             i_cfg,
    output mim_pkg::t_derived   o_drv,
    output logic                o_ready
);
    import mim_pkg::*;

    logic [31:0] r_mass, r_inertia, r_lin, r_ang, r_gain, r_radius, r_hx, r_hy;
    logic [31:0] r_scale, r_tau, r_turn, r_lin_t, r_ang_t;
    t_cfg_state  r_state, n_state;
    logic        w_write;
    logic        div_start, div_busy, div_done, div_sat;
    logic [63:0] div_num;
    logic [31:0] div_den, div_quo, w_cap;
    logic [32:0] w_lever;
    logic [64:0] w_prod;

    assign w_write     = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign w_lever     = {1'b0, r_hx} + {1'b0, r_hy};
    assign w_prod      = {33'd0, r_scale} * {32'd0, w_lever};
    assign w_cap       = cap_mag(div_sat, div_quo);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CF_S_GO:   if (!div_busy) n_state = CF_S_WAIT;
            CF_S_WAIT: if (div_done)  n_state = CF_TAU;
            CF_TAU:                   n_state = CF_T_GO;
            CF_T_GO:   if (!div_busy) n_state = CF_T_WAIT;
            CF_T_WAIT: if (div_done)  n_state = CF_L_GO;
            CF_L_GO:   if (!div_busy) n_state = CF_L_WAIT;
            CF_L_WAIT: if (div_done)  n_state = CF_A_GO;
            CF_A_GO:   if (!div_busy) n_state = CF_A_WAIT;
            CF_A_WAIT: if (div_done)  n_state = CF_DONE;
            CF_DONE:                  n_state = CF_DONE;
            default:                  n_state = CF_S_GO;
        endcase
        if (w_write) n_state = CF_S_GO;
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = {16'd0, r_gain, 16'd0};
        div_den   = r_radius;
        unique case (r_state)
            CF_S_GO: div_start = !div_busy && !w_write;
            CF_T_GO: begin
                div_start = !div_busy && !w_write;
                div_num   = {16'd0, r_tau, 16'd0};
                div_den   = r_inertia;
            end
            CF_L_GO: begin
                div_start = !div_busy && !w_write;
                div_num   = {16'd0, r_lin, 16'd0};
                div_den   = r_mass;
            end
            CF_A_GO: begin
                div_start = !div_busy && !w_write;
                div_num   = {16'd0, r_ang, 16'd0};
                div_den   = r_inertia;
            end
            default: div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= CF_S_GO;
            r_mass   <= 32'h0001_0000;
            r_inertia <= 32'h0001_0000;
            r_lin    <= 32'd0;
            r_ang    <= 32'd0;
            r_gain   <= 32'h0001_0000;
            r_radius <= 32'h0001_0000;
            r_hx     <= 32'd0;
            r_hy     <= 32'd0;
        end else begin
            r_state <= n_state;
            if (w_write) begin
                case (i_cfg.index)
                    REG_MASS:            r_mass    <= i_cfg.data;
                    REG_INERTIA:         r_inertia <= i_cfg.data;
                    REG_LINEAR_DAMPING:  r_lin     <= i_cfg.data;
                    REG_ANGULAR_DAMPING: r_ang     <= i_cfg.data;
                    REG_MOTOR_GAIN:      r_gain    <= i_cfg.data;
                    REG_WHEEL_RADIUS:    r_radius  <= i_cfg.data;
                    REG_HALF_LENGTH_X:   r_hx      <= i_cfg.data;
                    REG_HALF_LENGTH_Y:   r_hy      <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done && !w_write) begin
            case (r_state)
                CF_S_WAIT: r_scale <= div_sat ? 32'hFFFF_FFFF : div_quo;
                CF_T_WAIT: r_turn  <= w_cap;
                CF_L_WAIT: r_lin_t <= sat_signed(1'b1, w_cap);
                CF_A_WAIT: r_ang_t <= sat_signed(1'b1, w_cap);
                default: ;
            endcase
        end
        if (r_state == CF_TAU) begin
            r_tau <= (w_prod[64:48] != 17'd0) ? 32'hFFFF_FFFF : w_prod[47:16];
        end
    end

    mim_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_sat   (div_sat)
    );

    assign o_drv.mass     = r_mass;
    assign o_drv.scale    = r_scale;
    assign o_drv.turn_mag = r_turn;
    assign o_drv.lin_term = r_lin_t;
    assign o_drv.ang_term = r_ang_t;
    assign o_ready        = (r_state == CF_DONE);
endmodule

[src/mim_front.sv]
// Front part: accepts headings and runs a pipelined 16-stage CORDIC that
// yields the two heading combinations for the back. Depends on mim_pkg, mim_if.
module mim_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mim_in_if.sink        i_angle,
    input  logic          i_cfg_ready,
    output mim_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_ready
);
    import mim_pkg::*;

    localparam int STAGES = 16;

    logic [STAGES+1:0]  r_v;
    logic signed [33:0] r_x [0:STAGES];
    logic signed [33:0] r_y [0:STAGES];
    logic signed [33:0] r_z [0:STAGES];
    logic [1:0]         r_q [0:STAGES];
    t_job               r_job;
    logic               w_en;
    logic signed [33:0] w_c, w_s;
    logic signed [17:0] w_cq, w_sq;
    logic signed [18:0] w_sum, w_dif;

    function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
        logic signed [34:0] t;
        t = ($signed({v[33], v}) + 35'sd8192) >>> 14;
        if (t > 35'sd65536) t = 35'sd65536;
        if (t < -35'sd65536) t = -35'sd65536;
        return t[17:0];
    endfunction

    assign w_en          = !r_v[STAGES+1] || i_job_ready;
    assign i_angle.ready = w_en && i_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[STAGES:0], i_angle.valid && i_angle.ready};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= 34'sd0;
            r_z[0] <= $signed({4'd0, i_angle.heading_angle[13:0], 16'd0});
            r_q[0] <= i_angle.heading_angle[15:14];
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_q[k+1] <= r_q[k];
                if (!r_z[k][33]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - cordic_atan(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + cordic_atan(k);
                end
            end
        end
    end

    // Quadrant fold, rounding to Q16.16 and the two combinations.
    always_comb begin
        case (r_q[STAGES])
            2'd0: begin w_c = r_x[STAGES];  w_s = r_y[STAGES];  end
            2'd1: begin w_c = -r_y[STAGES]; w_s = r_x[STAGES];  end
            2'd2: begin w_c = -r_x[STAGES]; w_s = -r_y[STAGES]; end
            default: begin w_c = r_y[STAGES]; w_s = -r_x[STAGES]; end
        endcase
        w_cq  = to_q16(w_c);
        w_sq  = to_q16(w_s);
        w_sum = {w_cq[17], w_cq} + {w_sq[17], w_sq};
        w_dif = {w_cq[17], w_cq} - {w_sq[17], w_sq};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_job.neg_sum <= w_sum[18];
            r_job.mag_sum <= w_sum[18] ? 18'(-w_sum) : w_sum[17:0];
            r_job.neg_dif <= w_dif[18];
            r_job.mag_dif <= w_dif[18] ? 18'(-w_dif) : w_dif[17:0];
        end
    end

    assign o_job       = r_job;
    assign o_job_valid = r_v[STAGES+1];
endmodule

[src/mim_fifo.sv]
// Short queue of angle jobs between the front and the back.
// Depends on mim_pkg.
module mim_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mim_pkg::t_job i_data,
    output logic          o_ready,
    input  logic          i_pop,
    output mim_pkg::t_job o_data,
    output logic          o_valid
);
    import mim_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (w_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (w_push && !w_pop) r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end
endmodule

[src/mim_back.sv]
// Back part: scales the heading combinations, divides by mass on two
// dividers and streams four wheel columns from an output bank.
// Depends on mim_pkg, mim_if, mim_div.
module mim_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mim_pkg::t_job     i_job,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    input  mim_pkg::t_derived i_drv,
    mim_out_if.source         o_col
);
    import mim_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [49:0] r_prod_sum, r_prod_dif;
    logic        r_done_sum, r_done_dif;
    logic [31:0] r_q_sum, r_q_dif;
    logic        r_bank_v;
    logic [1:0]  r_col;
    logic [31:0] r_g_sum, r_g_dif;
    logic        r_n_sum, r_n_dif;
    logic        w_start, w_load, w_free, w_xfer;
    logic        ds_busy, ds_done, ds_sat, dd_busy, dd_done, dd_sat;
    logic [31:0] ds_quo, dd_quo;

    assign w_xfer = o_col.valid && o_col.ready;
    assign w_free = !r_bank_v || (w_xfer && r_col == 2'(WHEEL_COUNT - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_job_valid) n_state = BK_MUL;
            BK_MUL:                   n_state = BK_GO;
            BK_GO:                    n_state = BK_WAIT;
            BK_WAIT: begin
                if ((r_done_sum || ds_done) && (r_done_dif || dd_done)) n_state = BK_LOAD;
            end
            BK_LOAD: if (w_free)      n_state = BK_IDLE;
            default:                  n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = (r_state == BK_IDLE) && i_job_valid;
        w_start   = (r_state == BK_GO);
        w_load    = (r_state == BK_LOAD) && w_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_done_sum <= 1'b0;
            r_done_dif <= 1'b0;
            r_bank_v   <= 1'b0;
            r_col      <= 2'd0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_done_sum <= 1'b0;
                r_done_dif <= 1'b0;
            end else begin
                if (ds_done) r_done_sum <= 1'b1;
                if (dd_done) r_done_dif <= 1'b1;
            end
            if (w_xfer) begin
                r_col <= (r_col == 2'(WHEEL_COUNT - 1)) ? 2'd0 : r_col + 2'd1;
            end
            if (w_load) begin
                r_bank_v <= 1'b1;
            end else if (w_xfer && r_col == 2'(WHEEL_COUNT - 1)) begin
                r_bank_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) r_job <= i_job;
        if (r_state == BK_MUL) begin
            r_prod_sum <= {18'd0, i_drv.scale} * {32'd0, r_job.mag_sum};
            r_prod_dif <= {18'd0, i_drv.scale} * {32'd0, r_job.mag_dif};
        end
        if (ds_done) r_q_sum <= cap_mag(ds_sat, ds_quo);
        if (dd_done) r_q_dif <= cap_mag(dd_sat, dd_quo);
        if (w_load) begin
            r_g_sum <= r_q_sum;
            r_g_dif <= r_q_dif;
            r_n_sum <= r_job.neg_sum;
            r_n_dif <= r_job.neg_dif;
        end
    end

    mim_div u_div_sum (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start),
        .i_num ({14'd0, r_prod_sum}), .i_den (i_drv.mass),
        .o_busy (ds_busy), .o_done (ds_done), .o_quo (ds_quo), .o_sat (ds_sat)
    );

    mim_div u_div_dif (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_start),
        .i_num ({14'd0, r_prod_dif}), .i_den (i_drv.mass),
        .o_busy (dd_busy), .o_done (dd_done), .o_quo (dd_quo), .o_sat (dd_sat)
    );

    // Left-front and right-rear share x = c+s and y = s-c; the other two
    // wheels use x = c-s and y = c+s.
    always_comb begin
        o_col.valid                = r_bank_v;
        o_col.wheel_index          = r_col;
        o_col.last_column          = (r_col == 2'(WHEEL_COUNT - 1));
        o_col.linear_damping_term  = i_drv.lin_term;
        o_col.angular_damping_term = i_drv.ang_term;
        case (r_col)
            WHEEL_FL, WHEEL_RR: begin
                o_col.world_x_gain = sat_signed(r_n_sum, r_g_sum);
                o_col.world_y_gain = sat_signed(!r_n_dif, r_g_dif);
            end
            default: begin
                o_col.world_x_gain = sat_signed(r_n_dif, r_g_dif);
                o_col.world_y_gain = sat_signed(r_n_sum, r_g_sum);
            end
        endcase
        case (r_col)
            WHEEL_FL, WHEEL_RL: o_col.turn_gain = sat_signed(1'b1, i_drv.turn_mag);
            default:            o_col.turn_gain = sat_signed(1'b0, i_drv.turn_mag);
        endcase
    end

    // The busy flags are only needed inside the dividers.
    logic w_unused;
    assign w_unused = ds_busy ^ dd_busy;
endmodule

[src/mecanum_input_matrix_core.sv]
// Top level of the mecanum input matrix block: heading in, four wheel columns out.
// Depends on mim_pkg, mim_if, mim_cfg, mim_front, mim_fifo, mim_back.
//
// Each accepted heading produces four column transfers in wheel order front
// left, front right, rear left, rear right, the fourth flagged last_column.
// Headings enter a 16-stage pipelined CORDIC that can take one heading every
// cycle unless the queue is full or configuration is in progress; finished
// angles wait in a short queue. The back part is paced by its two 32-step
// restoring dividers that divide the scaled force terms by mass; the four
// column transfers of one heading go out of an output bank while the
// dividers already work on the next. Headings with a zero or saturating
// dividend skip the bit-by-bit divider steps. After reset, and after every
// configuration write, the block derives the wheel scale, turn gain and
// damping terms on a shared divider and holds heading ready low meanwhile;
// configuration writes are taken at any time and indexes above seven are
// ignored. No memory clearing pass is needed.
module mecanum_input_matrix_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mim_in_if.sink     i_angle,
    mim_cfg_if.sink    i_cfg,
    mim_out_if.source  o_column
);
    import mim_pkg::*;

    t_derived drv;
    t_job     front_job, queue_job;
    logic     cfg_ready, front_valid, queue_ready, queue_valid, job_pop;

    mim_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_drv   (drv),
        .o_ready (cfg_ready)
    );

    // A heading is held back during a configuration transfer so that it
    // always sees the values in force after the write.
    mim_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_angle     (i_angle),
        .i_cfg_ready (cfg_ready && !i_cfg.valid),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (queue_ready)
    );

    mim_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_job),
        .o_ready (queue_ready),
        .i_pop   (job_pop),
        .o_data  (queue_job),
        .o_valid (queue_valid)
    );

    mim_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .i_job_valid (queue_valid),
        .o_job_pop   (job_pop),
        .i_drv       (drv),
        .o_col       (o_column)
    );
endmodule
